/* rtl/core/psgm_pkg.sv */
// Shared types, widths and codes for the probe sphere grid marker.
// Depends on nothing; every rtl/core file but psgm_ram refers to it by scoped names.
package psgm_pkg;

    // Grid size in cells
    localparam int GRID_X = 64;
    localparam int GRID_Y = 64;
    localparam int GRID_Z = 64;

    localparam int IW = $clog2(GRID_X);
    localparam int JW = $clog2(GRID_Y);
    localparam int KW = $clog2(GRID_Z);
    localparam int BOX_W = (IW > JW) ? ((IW > KW) ? IW : KW) : ((JW > KW) ? JW : KW);

    // One memory word holds one z row of the grid
    localparam int RAM_DEPTH = GRID_X * GRID_Y;
    localparam int AW = $clog2(RAM_DEPTH);

    // Field widths
    localparam int COORD_W = 24;
    localparam int RAD_W = 16;
    localparam int INV_W = 24;
    localparam int ROT_W = 18;
    localparam int CELL_W = 6;
    localparam int CFG_W = 36;
    localparam int CFG_IDX_W = 3;

    // Q16 coordinate widths after scaling and each rotation
    localparam int C1_W = COORD_W + 1 + INV_W + 1 - 8;
    localparam int C2_W = C1_W + 3;
    localparam int C3_W = C2_W + 3;

    // Enlarged radius, its square and the squared distance
    localparam int H_W = 31;
    localparam int H2_W = 2 * H_W;
    localparam int D2_W = H2_W + 2;
    localparam logic [H_W-1:0] H_MAX = '1;

    // Queue depth between front and back
    localparam int QDEPTH = 2;
    localparam int QPW = $clog2(QDEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_INV_STEP = 3'd3,
        CFG_PROBE_RADIUS = 3'd4,
        CFG_ROT_A = 3'd5,
        CFG_ROT_B = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic [INV_W-1:0] inv_step;
        logic [RAD_W-1:0] probe_radius;
        logic [CFG_W-1:0] rot_a;
        logic [CFG_W-1:0] rot_b;
    } cfg_t;

    // Classified command passed from front to back
    typedef struct packed {
        logic is_read;
        logic rd_in_grid;
        logic [IW-1:0] rd_i;
        logic [JW-1:0] rd_j;
        logic [KW-1:0] rd_k;
        logic signed [C3_W-1:0] cx;
        logic signed [C3_W-1:0] cy;
        logic signed [C3_W-1:0] cz;
        logic [H_W-1:0] h;
        logic [H2_W-1:0] h2;
        logic box_empty;
        logic [IW-1:0] ilo;
        logic [IW-1:0] ihi;
        logic [JW-1:0] jlo;
        logic [JW-1:0] jhi;
        logic [KW-1:0] klo;
        logic [KW-1:0] khi;
    } cmd_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SCALE,
        F_ROT1,
        F_ROT2,
        F_BOX,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_ROW0,
        B_ROW1,
        B_ROW2,
        B_WALK,
        B_DRAIN1,
        B_DRAIN2,
        B_WRITE,
        B_DONE,
        B_RD,
        B_RDW
    } back_state_t;

endpackage

/* rtl/core/probe_sphere_grid_marker_core.sv */
// Top level of the probe sphere grid marker: configuration registers,
// front part, command queue and back part. Depends on psgm_pkg and all rtl/core modules.
//
//   channel   signals                                         direction
//   input     in_valid/in_ready, opcode, atom_*, cell_*       in
//   result    out_valid/out_ready, cell_marked, mark_done     out
//   config    cfg_wr_en, cfg_index, cfg_wdata                 in, no handshake
//
// A read item goes from the front idle state straight to its push state. A mark item
// passes the front states scale, rotation one, rotation two and box; in the back part a
// box row outside the sphere is skipped; a row that meets it is read, walked over the
// z cells of the box and written back. After reset the back part clears the grid one row
// per cycle, GRID_X*GRID_Y = 4096 rows, while in_ready stays low. A stalled result holds
// the back part; the queue and the front part take up to three further items.
module probe_sphere_grid_marker_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  opcode,
    input  logic signed [psgm_pkg::COORD_W-1:0]   atom_x,
    input  logic signed [psgm_pkg::COORD_W-1:0]   atom_y,
    input  logic signed [psgm_pkg::COORD_W-1:0]   atom_z,
    input  logic [psgm_pkg::RAD_W-1:0]            atom_radius,
    input  logic [psgm_pkg::CELL_W-1:0]           cell_x,
    input  logic [psgm_pkg::CELL_W-1:0]           cell_y,
    input  logic [psgm_pkg::CELL_W-1:0]           cell_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  cell_marked,
    output logic                                  mark_done,
    input  logic                                  cfg_wr_en,
    input  logic [psgm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psgm_pkg::CFG_W-1:0]            cfg_wdata
);

    psgm_pkg::cfg_t cfg_reg;
    psgm_pkg::cmd_t q_data, q_head;
    logic q_push, q_full, q_pop, q_empty, clear_busy;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.origin_z <= '0;
            cfg_reg.inv_step <= 24'd109227;
            cfg_reg.probe_radius <= 16'd358;
            cfg_reg.rot_a <= 36'h4_0000_0000;
            cfg_reg.rot_b <= 36'h4_0000_0000;
        end
        else if (cfg_wr_en)
        begin
            case (psgm_pkg::cfg_idx_t'(cfg_index))
                psgm_pkg::CFG_ORIGIN_X: cfg_reg.origin_x <= cfg_wdata[23:0];
                psgm_pkg::CFG_ORIGIN_Y: cfg_reg.origin_y <= cfg_wdata[23:0];
                psgm_pkg::CFG_ORIGIN_Z: cfg_reg.origin_z <= cfg_wdata[23:0];
                psgm_pkg::CFG_INV_STEP: cfg_reg.inv_step <= cfg_wdata[23:0];
                psgm_pkg::CFG_PROBE_RADIUS: cfg_reg.probe_radius <= cfg_wdata[15:0];
                psgm_pkg::CFG_ROT_A: cfg_reg.rot_a <= cfg_wdata;
                psgm_pkg::CFG_ROT_B: cfg_reg.rot_b <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    psgm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .enable      (!clear_busy),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .atom_x      (atom_x),
        .atom_y      (atom_y),
        .atom_z      (atom_z),
        .atom_radius (atom_radius),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_z      (cell_z),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    psgm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    psgm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .clear_busy  (clear_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_marked (cell_marked),
        .mark_done   (mark_done)
    );

endmodule

/* rtl/core/psgm_ram.sv */
// Generic single write, single read RAM with registered read data.
// Depends on nothing.
module psgm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/psgm_queue.sv */
// Short command queue between the front and back parts.
// Depends on psgm_pkg.
module psgm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  psgm_pkg::cmd_t   push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output psgm_pkg::cmd_t   head
);

    psgm_pkg::cmd_t entry_reg [psgm_pkg::QDEPTH];
    logic [psgm_pkg::QPW-1:0] wr_ptr_reg;
    logic [psgm_pkg::QPW-1:0] wr_ptr_next;
    logic [psgm_pkg::QPW-1:0] rd_ptr_reg;
    logic [psgm_pkg::QPW-1:0] rd_ptr_next;
    logic [psgm_pkg::QPW:0] count_reg;
    logic [psgm_pkg::QPW:0] count_next;

    assign full = (count_reg == (psgm_pkg::QPW+1)'(psgm_pkg::QDEPTH));
    assign empty = (count_reg == '0);
    assign head = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == psgm_pkg::QPW'(psgm_pkg::QDEPTH - 1)) ?
                '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == psgm_pkg::QPW'(psgm_pkg::QDEPTH - 1)) ?
                '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (psgm_pkg::QPW+1)'(psgm_pkg::QDEPTH))
        else $error("queue count beyond depth");

endmodule

/* rtl/core/psgm_front.sv */
// Front part: accepts items, scales and rotates atom centres, builds the box.
// Depends on psgm_pkg; pushes commands into psgm_queue.
module psgm_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  psgm_pkg::cfg_t                        cfg,
    input  logic                                  enable,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  opcode,
    input  logic signed [psgm_pkg::COORD_W-1:0]   atom_x,
    input  logic signed [psgm_pkg::COORD_W-1:0]   atom_y,
    input  logic signed [psgm_pkg::COORD_W-1:0]   atom_z,
    input  logic [psgm_pkg::RAD_W-1:0]            atom_radius,
    input  logic [psgm_pkg::CELL_W-1:0]           cell_x,
    input  logic [psgm_pkg::CELL_W-1:0]           cell_y,
    input  logic [psgm_pkg::CELL_W-1:0]           cell_z,
    input  logic                                  q_full,
    output logic                                  q_push,
    output psgm_pkg::cmd_t                        q_data
);

    localparam int DW = psgm_pkg::COORD_W + 1;
    localparam int C1 = psgm_pkg::C1_W;
    localparam int C2 = psgm_pkg::C2_W;
    localparam int C3 = psgm_pkg::C3_W;
    localparam int BQ_W = C3 + 2 - 16;
    localparam int HP_W = psgm_pkg::RAD_W + 1 + psgm_pkg::INV_W;

    typedef struct packed {
        logic empty;
        logic [psgm_pkg::BOX_W-1:0] lo;
        logic [psgm_pkg::BOX_W-1:0] hi;
    } box_t;

    psgm_pkg::front_state_t state_reg, state_next;
    logic signed [DW-1:0] dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [psgm_pkg::RAD_W:0] rsum_reg, rsum_next;
    logic signed [C1-1:0] x1_reg, x1_next, y1_reg, y1_next, z1_reg, z1_next;
    logic [psgm_pkg::H_W-1:0] h_reg, h_next;
    logic [psgm_pkg::H2_W-1:0] h2_reg, h2_next;
    logic signed [C2-1:0] xa_reg, xa_next, za_reg, za_next;
    psgm_pkg::cmd_t cmd_reg, cmd_next;

    logic signed [DW-1:0] inv_s;
    logic signed [2*DW-1:0] px, py, pz;
    logic [HP_W-1:0] hprod;
    logic [HP_W-9:0] hq;
    logic signed [psgm_pkg::ROT_W-1:0] ca, sa, cb, sb;
    logic signed [C1+psgm_pkg::ROT_W-1:0] p_xc, p_zs, p_zc, p_xs;
    logic signed [C1+psgm_pkg::ROT_W:0] s_xa, s_za;
    logic signed [C2-1:0] ya_ext;
    logic signed [C2+psgm_pkg::ROT_W-1:0] p_yc, p_zsa, p_ys, p_zca;
    logic signed [C2+psgm_pkg::ROT_W:0] s_cy, s_cz;
    box_t bx, by, bz;

    // Floor and ceiling of centre -/+ radius in whole cells, clamped to the grid
    function automatic box_t axis_box(input logic signed [C3-1:0] c,
                                      input logic [psgm_pkg::H_W-1:0] h,
                                      input int lim);
        logic signed [C3+1:0] lo_q;
        logic signed [C3+1:0] hi_q;
        logic signed [BQ_W-1:0] lo;
        logic signed [BQ_W-1:0] hi;
        logic signed [BQ_W-1:0] lim_m1;
        logic signed [BQ_W-1:0] lo_c;
        logic signed [BQ_W-1:0] hi_c;
        box_t b;
        lo_q = (C3+2)'(c) - (C3+2)'($signed({1'b0, h}));
        hi_q = (C3+2)'(c) + (C3+2)'($signed({1'b0, h})) + (C3+2)'(17'sh0FFFF);
        lo = lo_q[C3+1:16];
        hi = hi_q[C3+1:16];
        lim_m1 = BQ_W'(lim - 1);
        lo_c = (lo < 0) ? '0 : lo;
        hi_c = (hi > lim_m1) ? lim_m1 : hi;
        b.empty = (lo_c > hi_c);
        b.lo = psgm_pkg::BOX_W'(lo_c);
        b.hi = psgm_pkg::BOX_W'(hi_c);
        return b;
    endfunction

    // Arithmetic of each step
    always_comb
    begin
        inv_s = $signed({1'b0, cfg.inv_step});
        px = dx_reg * inv_s;
        py = dy_reg * inv_s;
        pz = dz_reg * inv_s;
        hprod = HP_W'(rsum_reg) * HP_W'(cfg.inv_step);
        hq = hprod[HP_W-1:8];

        ca = cfg.rot_a[35:18];
        sa = cfg.rot_a[17:0];
        cb = cfg.rot_b[35:18];
        sb = cfg.rot_b[17:0];
        p_xc = x1_reg * cb;
        p_zs = z1_reg * sb;
        p_zc = z1_reg * cb;
        p_xs = x1_reg * sb;
        s_xa = p_xc + p_zs;
        s_za = p_zc - p_xs;

        ya_ext = C2'(y1_reg);
        p_yc = ya_ext * ca;
        p_zsa = za_reg * sa;
        p_ys = ya_ext * sa;
        p_zca = za_reg * ca;
        s_cy = p_yc - p_zsa;
        s_cz = p_ys + p_zca;

        bx = axis_box(cmd_reg.cx, cmd_reg.h, psgm_pkg::GRID_X);
        by = axis_box(cmd_reg.cy, cmd_reg.h, psgm_pkg::GRID_Y);
        bz = axis_box(cmd_reg.cz, cmd_reg.h, psgm_pkg::GRID_Z);
    end

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        dz_next = dz_reg;
        rsum_next = rsum_reg;
        x1_next = x1_reg;
        y1_next = y1_reg;
        z1_next = z1_reg;
        h_next = h_reg;
        h2_next = h2_reg;
        xa_next = xa_reg;
        za_next = za_reg;
        cmd_next = cmd_reg;
        in_ready = 1'b0;
        q_push = 1'b0;
        case (state_reg)
            psgm_pkg::F_IDLE:
            begin
                in_ready = enable;
                if (enable && in_valid)
                begin
                    cmd_next = '0;
                    if (opcode)
                    begin
                        cmd_next.is_read = 1'b1;
                        cmd_next.rd_in_grid = (32'(cell_x) < psgm_pkg::GRID_X) &&
                                              (32'(cell_y) < psgm_pkg::GRID_Y) &&
                                              (32'(cell_z) < psgm_pkg::GRID_Z);
                        cmd_next.rd_i = psgm_pkg::IW'(cell_x);
                        cmd_next.rd_j = psgm_pkg::JW'(cell_y);
                        cmd_next.rd_k = psgm_pkg::KW'(cell_z);
                        state_next = psgm_pkg::F_PUSH;
                    end
                    else
                    begin
                        dx_next = DW'(atom_x) - DW'(cfg.origin_x);
                        dy_next = DW'(atom_y) - DW'(cfg.origin_y);
                        dz_next = DW'(atom_z) - DW'(cfg.origin_z);
                        rsum_next = (psgm_pkg::RAD_W+1)'(atom_radius) +
                                    (psgm_pkg::RAD_W+1)'(cfg.probe_radius);
                        state_next = psgm_pkg::F_SCALE;
                    end
                end
            end
            psgm_pkg::F_SCALE:
            begin
                x1_next = px[2*DW-1:8];
                y1_next = py[2*DW-1:8];
                z1_next = pz[2*DW-1:8];
                h_next = (hq > (HP_W-8)'(psgm_pkg::H_MAX)) ?
                         psgm_pkg::H_MAX : psgm_pkg::H_W'(hq);
                state_next = psgm_pkg::F_ROT1;
            end
            psgm_pkg::F_ROT1:
            begin
                xa_next = s_xa[C1+psgm_pkg::ROT_W:16];
                za_next = s_za[C1+psgm_pkg::ROT_W:16];
                h2_next = psgm_pkg::H2_W'(h_reg) * psgm_pkg::H2_W'(h_reg);
                state_next = psgm_pkg::F_ROT2;
            end
            psgm_pkg::F_ROT2:
            begin
                cmd_next.cx = C3'(xa_reg);
                cmd_next.cy = s_cy[C2+psgm_pkg::ROT_W:16];
                cmd_next.cz = s_cz[C2+psgm_pkg::ROT_W:16];
                cmd_next.h = h_reg;
                cmd_next.h2 = h2_reg;
                state_next = psgm_pkg::F_BOX;
            end
            psgm_pkg::F_BOX:
            begin
                cmd_next.box_empty = bx.empty || by.empty || bz.empty;
                cmd_next.ilo = psgm_pkg::IW'(bx.lo);
                cmd_next.ihi = psgm_pkg::IW'(bx.hi);
                cmd_next.jlo = psgm_pkg::JW'(by.lo);
                cmd_next.jhi = psgm_pkg::JW'(by.hi);
                cmd_next.klo = psgm_pkg::KW'(bz.lo);
                cmd_next.khi = psgm_pkg::KW'(bz.hi);
                state_next = psgm_pkg::F_PUSH;
            end
            psgm_pkg::F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push = 1'b1;
                    state_next = psgm_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = psgm_pkg::F_IDLE;
            end
        endcase
    end

    assign q_data = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psgm_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        dz_reg <= dz_next;
        rsum_reg <= rsum_next;
        x1_reg <= x1_next;
        y1_reg <= y1_next;
        z1_reg <= z1_next;
        h_reg <= h_next;
        h2_reg <= h2_next;
        xa_reg <= xa_next;
        za_reg <= za_next;
        cmd_reg <= cmd_next;
    end

    a_push_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psgm_pkg::F_PUSH && q_full) |=> state_reg == psgm_pkg::F_PUSH)
        else $error("front dropped a command while queue full");

    a_mark_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psgm_pkg::F_SCALE) |=> state_reg == psgm_pkg::F_ROT1)
        else $error("front skipped rotation");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("front accepted two items back to back");

endmodule

/* rtl/core/psgm_back.sv */
// Back part: clears the grid, walks sphere boxes row by row, serves reads.
// Depends on psgm_pkg and psgm_ram; pops commands from psgm_queue.
module psgm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  psgm_pkg::cmd_t        q_head,
    output logic                  q_pop,
    output logic                  clear_busy,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  cell_marked,
    output logic                  mark_done
);

    localparam int C3 = psgm_pkg::C3_W;
    localparam int HW = psgm_pkg::H_W;

    psgm_pkg::back_state_t state_reg, state_next;
    psgm_pkg::cmd_t cmd_reg, cmd_next;
    logic [psgm_pkg::AW-1:0] clr_reg, clr_next;
    logic [psgm_pkg::IW-1:0] i_reg, i_next;
    logic [psgm_pkg::JW-1:0] j_reg, j_next;
    logic [psgm_pkg::KW-1:0] k_reg, k_next;
    logic [HW-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic [psgm_pkg::H2_W-1:0] sqx_reg, sqx_next;
    logic [psgm_pkg::D2_W-1:0] sxy_reg, sxy_next;
    logic [psgm_pkg::GRID_Z-1:0] mask_reg, mask_next;
    logic p1_valid_reg, p2_valid_reg;
    logic [psgm_pkg::KW-1:0] p1_k_reg, p2_k_reg;
    logic [HW-1:0] p1_az_reg;
    logic [psgm_pkg::H2_W-1:0] p2_sq_reg;
    logic out_valid_reg, out_valid_next;
    logic marked_reg, marked_next;
    logic done_reg, done_next;

    logic ram_we, ram_re;
    logic [psgm_pkg::AW-1:0] ram_waddr, ram_raddr;
    logic [psgm_pkg::GRID_Z-1:0] ram_wdata, ram_rdata;

    logic [C3:0] mag_x, mag_y, mag_z;
    logic ok_x, ok_y, ok_z, last_i, last_j, out_free, hit;
    logic [psgm_pkg::AW-1:0] row_addr;

    function automatic logic [C3:0] offset_mag(input logic [psgm_pkg::BOX_W-1:0] idx,
                                               input logic signed [C3-1:0] c);
        logic signed [C3:0] e;
        e = (C3+1)'($signed({1'b0, idx, 16'h0000})) - (C3+1)'(c);
        return e[C3] ? (C3+1)'(-e) : (C3+1)'(e);
    endfunction

    psgm_ram #(
        .WIDTH (psgm_pkg::GRID_Z),
        .DEPTH (psgm_pkg::RAM_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Offsets of the current row and cell from the centre
    always_comb
    begin
        mag_x = offset_mag(psgm_pkg::BOX_W'(i_reg), cmd_reg.cx);
        mag_y = offset_mag(psgm_pkg::BOX_W'(j_reg), cmd_reg.cy);
        mag_z = offset_mag(psgm_pkg::BOX_W'(k_reg), cmd_reg.cz);
        ok_x = mag_x < (C3+1)'(cmd_reg.h);
        ok_y = mag_y < (C3+1)'(cmd_reg.h);
        ok_z = mag_z < (C3+1)'(cmd_reg.h);
        last_i = (i_reg == cmd_reg.ihi);
        last_j = (j_reg == cmd_reg.jhi);
        out_free = !out_valid_reg || out_ready;
        hit = p2_valid_reg &&
              ((sxy_reg + psgm_pkg::D2_W'(p2_sq_reg)) < psgm_pkg::D2_W'(cmd_reg.h2));
    end

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        clr_next = clr_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        sqx_next = sqx_reg;
        sxy_next = sxy_reg;
        mask_next = mask_reg;
        out_valid_next = out_valid_reg && !out_ready;
        marked_next = marked_reg;
        done_next = done_reg;
        q_pop = 1'b0;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        row_addr = psgm_pkg::AW'(psgm_pkg::AW'(i_reg) * psgm_pkg::AW'(psgm_pkg::GRID_Y)) +
                   psgm_pkg::AW'(j_reg);
        ram_raddr = row_addr;

        // Collect hits of the cell pipeline into the row mask
        if (hit)
        begin
            mask_next[p2_k_reg] = 1'b1;
        end

        case (state_reg)
            psgm_pkg::B_CLEAR:
            begin
                ram_we = 1'b1;
                ram_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == psgm_pkg::AW'(psgm_pkg::RAM_DEPTH - 1))
                begin
                    state_next = psgm_pkg::B_IDLE;
                end
            end
            psgm_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    cmd_next = q_head;
                    i_next = q_head.ilo;
                    j_next = q_head.jlo;
                    if (q_head.is_read)
                    begin
                        state_next = psgm_pkg::B_RD;
                    end
                    else if (q_head.box_empty)
                    begin
                        state_next = psgm_pkg::B_DONE;
                    end
                    else
                    begin
                        state_next = psgm_pkg::B_ROW0;
                    end
                end
            end
            psgm_pkg::B_ROW0:
            begin
                if (!ok_x)
                begin
                    // Whole x slice lies outside the sphere
                    j_next = cmd_reg.jlo;
                    if (last_i)
                    begin
                        state_next = psgm_pkg::B_DONE;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else if (!ok_y)
                begin
                    if (last_j)
                    begin
                        j_next = cmd_reg.jlo;
                        if (last_i)
                        begin
                            state_next = psgm_pkg::B_DONE;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    ram_re = 1'b1;
                    ax_next = HW'(mag_x);
                    ay_next = HW'(mag_y);
                    mask_next = '0;
                    state_next = psgm_pkg::B_ROW1;
                end
            end
            psgm_pkg::B_ROW1:
            begin
                sqx_next = psgm_pkg::H2_W'(ax_reg) * psgm_pkg::H2_W'(ax_reg);
                state_next = psgm_pkg::B_ROW2;
            end
            psgm_pkg::B_ROW2:
            begin
                sxy_next = psgm_pkg::D2_W'(sqx_reg) +
                           psgm_pkg::D2_W'(psgm_pkg::H2_W'(ay_reg) * psgm_pkg::H2_W'(ay_reg));
                k_next = cmd_reg.klo;
                state_next = psgm_pkg::B_WALK;
            end
            psgm_pkg::B_WALK:
            begin
                if (k_reg == cmd_reg.khi)
                begin
                    state_next = psgm_pkg::B_DRAIN1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            psgm_pkg::B_DRAIN1:
            begin
                state_next = psgm_pkg::B_DRAIN2;
            end
            psgm_pkg::B_DRAIN2:
            begin
                state_next = psgm_pkg::B_WRITE;
            end
            psgm_pkg::B_WRITE:
            begin
                ram_we = 1'b1;
                ram_waddr = row_addr;
                ram_wdata = ram_rdata | mask_reg;
                state_next = psgm_pkg::B_ROW0;
                if (last_j)
                begin
                    j_next = cmd_reg.jlo;
                    if (last_i)
                    begin
                        state_next = psgm_pkg::B_DONE;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            psgm_pkg::B_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    marked_next = 1'b0;
                    done_next = 1'b1;
                    state_next = psgm_pkg::B_IDLE;
                end
            end
            psgm_pkg::B_RD:
            begin
                ram_re = cmd_reg.rd_in_grid;
                ram_raddr = psgm_pkg::AW'(psgm_pkg::AW'(cmd_reg.rd_i) *
                            psgm_pkg::AW'(psgm_pkg::GRID_Y)) + psgm_pkg::AW'(cmd_reg.rd_j);
                state_next = psgm_pkg::B_RDW;
            end
            psgm_pkg::B_RDW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    marked_next = cmd_reg.rd_in_grid && ram_rdata[cmd_reg.rd_k];
                    done_next = 1'b0;
                    state_next = psgm_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = psgm_pkg::B_IDLE;
            end
        endcase
    end

    assign clear_busy = (state_reg == psgm_pkg::B_CLEAR);
    assign out_valid = out_valid_reg;
    assign cell_marked = marked_reg;
    assign mark_done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psgm_pkg::B_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
            p1_valid_reg <= (state_reg == psgm_pkg::B_WALK) && ok_z;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    // Datapath and cell pipeline: offset, then square, then compare
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
        ax_reg <= ax_next;
        ay_reg <= ay_next;
        sqx_reg <= sqx_next;
        sxy_reg <= sxy_next;
        mask_reg <= mask_next;
        marked_reg <= marked_next;
        done_reg <= done_next;
        p1_k_reg <= k_reg;
        p1_az_reg <= HW'(mag_z);
        p2_k_reg <= p1_k_reg;
        p2_sq_reg <= psgm_pkg::H2_W'(p1_az_reg) * psgm_pkg::H2_W'(p1_az_reg);
    end

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == psgm_pkg::B_WRITE || state_reg == psgm_pkg::B_CLEAR))
        else $error("grid written outside clear or row write");

    a_pipe_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        p2_valid_reg |-> (state_reg == psgm_pkg::B_WALK || state_reg == psgm_pkg::B_DRAIN1 ||
                          state_reg == psgm_pkg::B_DRAIN2))
        else $error("cell pipeline active outside a row walk");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !q_pop)
        else $error("command taken during clearing pass");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(done_reg)))
        else $error("stalled result changed");

endmodule
